>>> rtl/core/ers_pkg.sv
// Shared widths, types and codes for the ellipse raster stepper.
package ers_pkg;

  localparam int COORD_BITS = 16;
  localparam int AXIS_BITS  = 12;

  localparam int PIX_BITS  = COORD_BITS + 1;
  localparam int OFS_BITS  = AXIS_BITS + 1;
  localparam int SQ_BITS   = 2 * AXIS_BITS;
  localparam int MA_BITS   = AXIS_BITS + 2;
  localparam int MB_BITS   = SQ_BITS + 1;
  localparam int PROD_BITS = MA_BITS + MB_BITS;
  localparam int ERR_BITS  = PROD_BITS + 5;
  localparam int TE_BITS   = ERR_BITS + 1;
  localparam int SUM_BITS  = COORD_BITS + OFS_BITS + 2;

  localparam logic signed [OFS_BITS-1:0] OFS_ONE = OFS_BITS'(1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SQA  = 12'b0000_0000_0010,
    S_SQB  = 12'b0000_0000_0100,
    S_ERR0 = 12'b0000_0000_1000,
    S_INIT = 12'b0000_0001_0000,
    S_MULX = 12'b0000_0010_0000,
    S_TSTX = 12'b0000_0100_0000,
    S_MULY = 12'b0000_1000_0000,
    S_TSTY = 12'b0001_0000_0000,
    S_UPDX = 12'b0010_0000_0000,
    S_UPDY = 12'b0100_0000_0000,
    S_EMIT = 12'b1000_0000_0000
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_DONE = 3'b001,
    PH_MAIN = 3'b010,
    PH_TIP  = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    PAT_AXES = 4'b0001,
    PAT_QUAD = 4'b0010,
    PAT_TIP  = 4'b0100,
    PAT_NONE = 4'b1000
  } pattern_t;

endpackage

>>> rtl/core/ellipse_raster_stepper_unit.sv
// Ellipse raster stepper: sequencer around one shared multiplier plus output register.
//
// Usage: send a start transaction (op = 0) with center and semi-axes, then step
// transactions (op = 1), one loop iteration each, until a result shows shape_done.
// Input channel: in_valid / in_stall; a transaction moves when in_valid is high and
// in_stall is low. in_stall stays high while an item is being computed or its
// results are still being issued, so one item is in the block at a time.
// Result channel: out_valid / out_stall with a registered payload; out_last marks
// the final result of an item, pixel_valid low marks a result with no pixel.
// Steps per item:
//   start with nonzero axes: a*a, b*b, b*b*(2a-1), init add, then 4 results;
//   step in the main loop: two products and compares, two error updates, then
//   four results, or one; step on the tip: two results; any other item: one result.
// All products of an item share the one 14x25-bit signed multiplier, each in a
// state of its own, and each error update is one add.
// When the receiver stalls, the output register holds its result and the
// sequencer waits in the issue state. Reset clears the sequencer, the output
// valid and puts the ellipse in the finished phase, so a step before any start
// gives one result with no pixel and shape_done set.
module ellipse_raster_stepper_unit
  import ers_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic [AXIS_BITS-1:0]        in_semi_a,
  input  logic [AXIS_BITS-1:0]        in_semi_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pixel_valid,
  output logic signed [PIX_BITS-1:0]  out_pixel_x,
  output logic signed [PIX_BITS-1:0]  out_pixel_y,
  output logic                        out_last,
  output logic                        out_shape_done
);

  // Sequencer and algorithm phase
  seq_state_t state_r, state_nxt;
  phase_t     phase_r;

  // Ellipse state
  logic signed [OFS_BITS-1:0]   x_r, y_r;
  logic signed [ERR_BITS-1:0]   err_r;
  logic [SQ_BITS-1:0]           a2_r, b2_r;
  logic [AXIS_BITS-1:0]         a_r, b_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;

  // Shared multiplier and step scratch
  logic signed [MA_BITS-1:0]    mul_a;
  logic [SQ_BITS-1:0]           mul_b;
  logic signed [PROD_BITS-1:0]  mul_p;
  logic signed [PROD_BITS-1:0]  prod_r;
  logic signed [ERR_BITS-1:0]   inc_x_r, inc_y_r;
  logic                         adv_x_r, adv_y_r;
  logic signed [TE_BITS-1:0]    twice_e;
  logic signed [TE_BITS-1:0]    prod_ext;

  // Result issue
  pattern_t                     kind_r;
  logic signed [OFS_BITS-1:0]   ex_r, ey_r;
  logic                         done_r;
  logic [1:0]                   k_r, last_k_r;
  logic                         out_valid_r;
  logic                         out_pixel_valid_r;
  logic signed [PIX_BITS-1:0]   out_pixel_x_r, out_pixel_y_r;
  logic                         out_last_r, out_shape_done_r;

  logic                         in_take, out_free;
  logic signed [OFS_BITS-1:0]   y_step, y_after;
  logic signed [OFS_BITS-1:0]   b_s;
  logic signed [OFS_BITS:0]     dx, dy, ex_w, ey_w;
  logic signed [SUM_BITS-1:0]   px_sum, py_sum;
  logic                         res_valid, res_last;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = out_pixel_valid_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_last        = out_last_r;
  assign out_shape_done  = out_shape_done_r;

  assign b_s     = signed'(OFS_BITS'(b_r));
  assign y_step  = y_r + OFS_ONE;
  assign y_after = adv_y_r ? y_step : y_r;

  // Multiplier operand select: squares and the initial error product on start, then the two error products
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQA: begin
        mul_a = signed'(MA_BITS'(a_r));
        mul_b = SQ_BITS'(a_r);
      end
      S_SQB: begin
        mul_a = signed'(MA_BITS'(b_r));
        mul_b = SQ_BITS'(b_r);
      end
      S_ERR0: begin
        mul_a = signed'(MA_BITS'({a_r, 1'b0} - (AXIS_BITS + 1)'(1)));
        mul_b = b2_r;
      end
      S_MULX: begin
        mul_a = MA_BITS'(signed'({x_r, 1'b1}));
        mul_b = b2_r;
      end
      S_MULY: begin
        mul_a = MA_BITS'(signed'({y_r, 1'b1}));
        mul_b = a2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = PROD_BITS'(mul_a) * PROD_BITS'(signed'({1'b0, mul_b}));
  assign twice_e  = signed'({err_r, 1'b0});
  assign prod_ext = TE_BITS'(prod_r);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_op == OP_START) begin
            if (in_semi_a == '0 || in_semi_b == '0) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_SQA;
            end
          end else if (phase_r == PH_MAIN) begin
            state_nxt = S_MULX;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SQA:  state_nxt = S_SQB;
      S_SQB:  state_nxt = S_ERR0;
      S_ERR0: state_nxt = S_INIT;
      S_INIT: state_nxt = S_EMIT;
      S_MULX: state_nxt = S_TSTX;
      S_TSTX: state_nxt = S_MULY;
      S_MULY: state_nxt = S_TSTY;
      S_TSTY: state_nxt = S_UPDX;
      S_UPDX: state_nxt = S_UPDY;
      S_UPDY: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free && k_r == last_k_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DONE;
    end else begin
      state_r <= state_nxt;
      if (in_take && in_op == OP_START) begin
        phase_r <= (in_semi_a == '0 || in_semi_b == '0) ? PH_DONE : PH_MAIN;
      end else if (in_take && phase_r == PH_TIP) begin
        phase_r <= (y_r < b_s && y_step < b_s) ? PH_TIP : PH_DONE;
      end else if (state_r == S_UPDY && x_r == '0) begin
        phase_r <= (y_after < b_s) ? PH_TIP : PH_DONE;
      end
    end
  end

  // Datapath: one multiply or one wide add per cycle
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          k_r <= '0;
          if (in_op == OP_START) begin
            cx_r <= in_center_x;
            cy_r <= in_center_y;
            if (in_semi_a == '0 || in_semi_b == '0) begin
              kind_r   <= PAT_NONE;
              done_r   <= 1'b1;
              last_k_r <= 2'd0;
            end else begin
              a_r  <= in_semi_a;
              b_r  <= in_semi_b;
              x_r  <= -signed'(OFS_BITS'(in_semi_a));
              y_r  <= '0;
              ex_r <= -signed'(OFS_BITS'(in_semi_a));
              ey_r <= signed'(OFS_BITS'(in_semi_b));
            end
          end else if (phase_r == PH_TIP && y_r < b_s) begin
            // Emit the tip pair at the old row, then advance the row
            kind_r   <= PAT_TIP;
            ex_r     <= x_r;
            ey_r     <= y_r;
            y_r      <= y_step;
            done_r   <= !(y_step < b_s);
            last_k_r <= 2'd1;
          end else if (phase_r != PH_MAIN) begin
            kind_r   <= PAT_NONE;
            done_r   <= 1'b1;
            last_k_r <= 2'd0;
          end
        end
      end
      S_SQA:  a2_r   <= SQ_BITS'(mul_p);
      S_SQB:  b2_r   <= SQ_BITS'(mul_p);
      S_ERR0: prod_r <= mul_p;
      S_INIT: begin
        err_r    <= ERR_BITS'(signed'({1'b0, a2_r})) - ERR_BITS'(prod_r);
        kind_r   <= PAT_AXES;
        done_r   <= 1'b0;
        last_k_r <= 2'd3;
      end
      S_MULX: prod_r <= mul_p;
      S_TSTX: begin
        // x test against the old error; increment uses the advanced x
        adv_x_r <= (twice_e >= prod_ext);
        inc_x_r <= ERR_BITS'(prod_r) + ERR_BITS'(signed'({1'b0, b2_r, 1'b0}));
      end
      S_MULY: prod_r <= mul_p;
      S_TSTY: begin
        adv_y_r <= (twice_e <= prod_ext);
        inc_y_r <= ERR_BITS'(prod_r) + ERR_BITS'(signed'({1'b0, a2_r, 1'b0}));
      end
      S_UPDX: begin
        if (adv_x_r) begin
          x_r   <= x_r + OFS_ONE;
          err_r <= err_r + inc_x_r;
        end
      end
      S_UPDY: begin
        if (adv_y_r) begin
          y_r   <= y_step;
          err_r <= err_r + inc_y_r;
        end
        if (x_r != '0) begin
          kind_r   <= PAT_QUAD;
          ex_r     <= x_r;
          ey_r     <= y_after;
          done_r   <= 1'b0;
          last_k_r <= 2'd3;
        end else begin
          kind_r   <= PAT_NONE;
          done_r   <= !(y_after < b_s);
          last_k_r <= 2'd0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          k_r <= k_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Offsets of the result at issue index k
  assign ex_w = (OFS_BITS + 1)'(ex_r);
  assign ey_w = (OFS_BITS + 1)'(ey_r);

  always_comb begin
    dx        = '0;
    dy        = '0;
    res_valid = 1'b1;
    unique case (kind_r)
      PAT_AXES: begin
        case (k_r)
          2'd0:    dx = ex_w;
          2'd1:    dy = ey_w;
          2'd2:    dx = -ex_w;
          default: dy = -ey_w;
        endcase
      end
      PAT_QUAD: begin
        dx = k_r[0] ? -ex_w : ex_w;
        dy = k_r[1] ? -ey_w : ey_w;
      end
      PAT_TIP: begin
        dx = k_r[0] ? -ex_w : ex_w;
        dy = k_r[0] ? -ey_w : ey_w;
      end
      default: res_valid = 1'b0;
    endcase
  end

  assign px_sum   = SUM_BITS'(cx_r) + SUM_BITS'(dx);
  assign py_sum   = SUM_BITS'(cy_r) + SUM_BITS'(dy);
  assign res_last = (k_r == last_k_r);

  // Output register: load a result when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_pixel_valid_r <= res_valid;
      out_pixel_x_r     <= res_valid ? PIX_BITS'(px_sum) : '0;
      out_pixel_y_r     <= res_valid ? PIX_BITS'(py_sum) : '0;
      out_last_r        <= res_last;
      out_shape_done_r  <= res_last && done_r;
    end
  end

endmodule
